[rtl/core/tvg_pkg.sv]
`timescale 1ns / 1ps
package tvg_pkg;

  localparam int unsigned IDX_W           = 9;
  localparam int unsigned PREC_W          = 9;
  localparam int unsigned RAD_W           = 15;
  localparam int unsigned PHASE_W         = 32;
  localparam int unsigned NUM_W           = IDX_W + PHASE_W;
  localparam int unsigned TEX_FRAC        = 15;
  localparam int unsigned TRIG_W          = 32;
  localparam int unsigned VTX_LAT         = 4;
  localparam int unsigned ATAN_COUNT      = 24;
  localparam int unsigned DEF_MAX_PREC    = 256;
  localparam int unsigned DEF_CORDIC_STG  = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRECISION   = 2'd0,
    CFG_RING_RADIUS = 2'd1,
    CFG_TUBE_RADIUS = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0] ring_index;
    logic [IDX_W-1:0] segment_index;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        tex_s;
    logic [15:0]        tex_t;
    logic [47:0]        bitangent_packed;
    logic [47:0]        tangent_packed;
  } result_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [47:0]        bitangent_packed;
    logic [47:0]        tangent_packed;
  } geom_t;

  function automatic logic signed [TRIG_W-1:0] atan_turn(input int unsigned i);
    logic signed [TRIG_W-1:0] r;
    case (i)
      0: r = 32'sd536870912;
      1: r = 32'sd316933406;
      2: r = 32'sd167458907;
      3: r = 32'sd85004756;
      4: r = 32'sd42667331;
      5: r = 32'sd21354465;
      6: r = 32'sd10680862;
      7: r = 32'sd5340245;
      8: r = 32'sd2670163;
      9: r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [67:0] round_sr(input logic signed [67:0] v,
                                                  input int unsigned n);
    logic signed [67:0] one;
    one = 68'sd1;
    return (v + (one <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [15:0] sat_unit(input logic signed [67:0] v);
    logic signed [15:0] r;
    if (v > 68'sd16384) begin
      r = 16'sd16384;
    end else if (v < -68'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_pos(input logic signed [67:0] v);
    logic signed [15:0] r;
    if (v > 68'sd32767) begin
      r = 16'sd32767;
    end else if (v < -68'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/tvg_divider.sv]
`timescale 1ns / 1ps
module tvg_divider import tvg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [PREC_W-1:0] div_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o
);

  logic              v_w [NUM_W+1];
  logic [NUM_W-1:0]  n_w [NUM_W+1];
  logic [PREC_W-1:0] r_w [NUM_W+1];

  assign v_w[0] = valid_i;
  assign n_w[0] = num_i;
  assign r_w[0] = '0;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              v_q;
    logic [NUM_W-1:0]  n_q, n_d;
    logic [PREC_W-1:0] r_q, r_d;
    logic [PREC_W:0]   trial;
    logic              ge;

    always_comb begin
      trial = {r_w[i], n_w[i][NUM_W-1]};
      ge    = trial >= {1'b0, div_i};
      if (ge) begin
        r_d = PREC_W'(trial - {1'b0, div_i});
      end else begin
        r_d = trial[PREC_W-1:0];
      end
      n_d = {n_w[i][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      n_q <= n_d;
      r_q <= r_d;
    end

    assign v_w[i+1] = v_q;
    assign n_w[i+1] = n_q;
    assign r_w[i+1] = r_q;
  end

  assign valid_o = v_w[NUM_W];
  assign quot_o  = n_w[NUM_W];

endmodule

[rtl/core/tvg_cordic.sv]
`timescale 1ns / 1ps
module tvg_cordic import tvg_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STG
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [PHASE_W-1:0]       phase_i,
  output logic                     valid_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic                     v_w [CORDIC_STAGES+1];
  logic signed [TRIG_W-1:0] x_w [CORDIC_STAGES+1];
  logic signed [TRIG_W-1:0] y_w [CORDIC_STAGES+1];
  logic signed [TRIG_W-1:0] z_w [CORDIC_STAGES+1];
  logic [1:0]               q_w [CORDIC_STAGES+1];

  assign v_w[0] = valid_i;
  assign x_w[0] = CORDIC_GAIN;
  assign y_w[0] = '0;
  assign z_w[0] = $signed({2'b00, phase_i[PHASE_W-3:0]});
  assign q_w[0] = phase_i[PHASE_W-1:PHASE_W-2];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic                     v_q;
    logic signed [TRIG_W-1:0] x_q, y_q, z_q, x_d, y_d, z_d, dx, dy;
    logic [1:0]               q_q;

    always_comb begin
      dx = y_w[i] >>> i;
      dy = x_w[i] >>> i;
      if (!z_w[i][TRIG_W-1]) begin
        x_d = x_w[i] - dx;
        y_d = y_w[i] + dy;
        z_d = z_w[i] - atan_turn(i);
      end else begin
        x_d = x_w[i] + dx;
        y_d = y_w[i] - dy;
        z_d = z_w[i] + atan_turn(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      q_q <= q_w[i];
    end

    assign v_w[i+1] = v_q;
    assign x_w[i+1] = x_q;
    assign y_w[i+1] = y_q;
    assign z_w[i+1] = z_q;
    assign q_w[i+1] = q_q;
  end

  logic signed [TRIG_W-1:0] xf, yf;
  assign xf = x_w[CORDIC_STAGES];
  assign yf = y_w[CORDIC_STAGES];

  always_comb begin
    case (q_w[CORDIC_STAGES])
      2'd0: begin
        cos_o = xf;
        sin_o = yf;
      end
      2'd1: begin
        cos_o = -yf;
        sin_o = xf;
      end
      2'd2: begin
        cos_o = -xf;
        sin_o = -yf;
      end
      default: begin
        cos_o = yf;
        sin_o = -xf;
      end
    endcase
  end

  assign valid_o = v_w[CORDIC_STAGES];

endmodule

[rtl/core/tvg_vertex.sv]
`timescale 1ns / 1ps
module tvg_vertex import tvg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [TRIG_W-1:0] ca_i,
  input  logic signed [TRIG_W-1:0] sa_i,
  input  logic signed [TRIG_W-1:0] cb_i,
  input  logic signed [TRIG_W-1:0] sb_i,
  input  logic [RAD_W-1:0]         ring_radius_i,
  input  logic [RAD_W-1:0]         tube_radius_i,
  output logic                     valid_o,
  output geom_t                    geom_o
);

  logic [VTX_LAT-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[VTX_LAT-2:0], valid_i};
    end
  end

  // stage 1: products
  logic signed [15:0]       tube_s;
  logic signed [47:0]       ts_q, tc_q;
  logic signed [63:0]       sacb_q, sasb_q, cacb_q, casb_q;
  logic signed [TRIG_W-1:0] ca1_q, sa1_q, cb1_q, sb1_q;

  assign tube_s = $signed({1'b0, tube_radius_i});

  always_ff @(posedge clk_i) begin
    ts_q   <= tube_s * sa_i;
    tc_q   <= tube_s * ca_i;
    sacb_q <= sa_i * cb_i;
    sasb_q <= sa_i * sb_i;
    cacb_q <= ca_i * cb_i;
    casb_q <= ca_i * sb_i;
    ca1_q  <= ca_i;
    sa1_q  <= sa_i;
    cb1_q  <= cb_i;
    sb1_q  <= sb_i;
  end

  // stage 2: tube offset and unit vectors
  logic signed [47:0]       diff;
  logic signed [47:0]       xt_full;
  logic signed [33:0]       xt_q;
  logic signed [TRIG_W-1:0] cb2_q, sb2_q;
  geom_t                    g2_d, g2_q, g3_q;
  logic signed [67:0]       e_sacb, e_sasb, e_cacb, e_casb, e_ca, e_sa, e_cb, e_sb, e_tc;

  always_comb begin
    diff    = $signed({3'b000, ring_radius_i, 30'b0}) - ts_q;
    xt_full = (diff + 48'sd8192) >>> 14;
    e_sacb  = sacb_q;
    e_sasb  = sasb_q;
    e_cacb  = cacb_q;
    e_casb  = casb_q;
    e_ca    = ca1_q;
    e_sa    = sa1_q;
    e_cb    = cb1_q;
    e_sb    = sb1_q;
    e_tc    = tc_q;
    g2_d                  = '0;
    g2_d.pos_y            = sat_pos(round_sr(e_tc, 32));
    g2_d.normal_x         = sat_unit(round_sr(-e_sacb, 46));
    g2_d.normal_y         = sat_unit(round_sr(e_ca, 16));
    g2_d.normal_z         = sat_unit(round_sr(e_sasb, 46));
    g2_d.bitangent_packed = {sat_unit(round_sr(-e_cb, 16)), 16'h0000,
                             sat_unit(round_sr(-e_sb, 16))};
    g2_d.tangent_packed   = {sat_unit(round_sr(-e_casb, 46)),
                             sat_unit(round_sr(e_sa, 16)),
                             sat_unit(round_sr(e_cacb, 46))};
  end

  always_ff @(posedge clk_i) begin
    xt_q  <= xt_full[33:0];
    cb2_q <= cb1_q;
    sb2_q <= sb1_q;
    g2_q  <= g2_d;
  end

  // stage 3: rotation of the tube offset
  logic signed [65:0] xcb_q, xsb_q;

  always_ff @(posedge clk_i) begin
    xcb_q <= xt_q * cb2_q;
    xsb_q <= xt_q * sb2_q;
    g3_q  <= g2_q;
  end

  // stage 4: round and saturate
  logic signed [67:0] e_xcb, e_xsb;
  geom_t              g4_d;

  always_comb begin
    e_xcb       = xcb_q;
    e_xsb       = xsb_q;
    g4_d        = g3_q;
    g4_d.pos_x  = sat_pos(round_sr(e_xcb, 48));
    g4_d.pos_z  = sat_pos(round_sr(-e_xsb, 48));
  end

  always_ff @(posedge clk_i) begin
    geom_o <= g4_d;
  end

  assign valid_o = v_q[VTX_LAT-1];

endmodule

[rtl/core/torus_vertex_generator_unit.sv]
`timescale 1ns / 1ps
// channel   signals                           beat taken when
// input     start_i, busy_o, item_i           start_i high and busy_o low
// result    valid_o, result_o                 valid_o high, one cycle only
// config    cfg_we_i, cfg_idx_i, cfg_data_i   cfg_we_i high
//
// one vertex per cycle; the path runs through the input register, the bit-per-stage
// divider, the cordic stages and the vertex stages.
// busy_o stays low: every stage advances each cycle, nothing waits.
// reset clears valid bits and restores the register defaults.
module torus_vertex_generator_unit import tvg_pkg::*; #(
  parameter int unsigned MAX_PRECISION = DEF_MAX_PREC,
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STG
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  item_t                item_i,
  output logic                 valid_o,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RAD_W-1:0]     cfg_data_i
);

  logic [PREC_W-1:0] precision_q;
  logic [RAD_W-1:0]  ring_radius_q, tube_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q   <= PREC_W'(48);
      ring_radius_q <= RAD_W'(8192);
      tube_radius_q <= RAD_W'(3277);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PRECISION:   precision_q   <= cfg_data_i[PREC_W-1:0];
        CFG_RING_RADIUS: ring_radius_q <= cfg_data_i;
        CFG_TUBE_RADIUS: tube_radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [PREC_W-1:0] p_eff;

  always_comb begin
    if (precision_q == '0) begin
      p_eff = PREC_W'(1);
    end else if (32'(precision_q) > MAX_PRECISION) begin
      p_eff = PREC_W'(MAX_PRECISION);
    end else begin
      p_eff = precision_q;
    end
  end

  assign busy_o = 1'b0;

  // input stage: saturate indexes, build numerators
  logic [IDX_W-1:0] ring_sat, seg_sat;
  logic [IDX_W:0]   sn2;
  logic [IDX_W-1:0] sn;
  logic [NUM_W-1:0] half_p, na_d, nb_d, ns_d, nt_d;
  logic [NUM_W-1:0] na_q, nb_q, ns_q, nt_q;
  logic             v0_q;

  always_comb begin
    ring_sat = (item_i.ring_index > p_eff) ? p_eff : item_i.ring_index;
    seg_sat  = (item_i.segment_index > p_eff) ? p_eff : item_i.segment_index;
    sn2      = {ring_sat, 1'b0};
    if (sn2 > {1'b0, p_eff}) begin
      sn = IDX_W'(sn2 - {1'b0, p_eff});
    end else begin
      sn = sn2[IDX_W-1:0];
    end
    half_p = NUM_W'(p_eff >> 1);
    na_d   = {seg_sat, {PHASE_W{1'b0}}} + half_p;
    nb_d   = {ring_sat, {PHASE_W{1'b0}}} + half_p;
    ns_d   = NUM_W'({sn, {TEX_FRAC{1'b0}}}) + half_p;
    nt_d   = NUM_W'({seg_sat, {TEX_FRAC{1'b0}}}) + half_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    na_q <= na_d;
    nb_q <= nb_d;
    ns_q <= ns_d;
    nt_q <= nt_d;
  end

  logic             dv_a, dv_b, dv_s, dv_t;
  logic [NUM_W-1:0] qa, qb, qs, qt;

  tvg_divider u_div_a (
    .clk_i, .rst_ni, .valid_i(v0_q), .num_i(na_q), .div_i(p_eff),
    .valid_o(dv_a), .quot_o(qa)
  );
  tvg_divider u_div_b (
    .clk_i, .rst_ni, .valid_i(v0_q), .num_i(nb_q), .div_i(p_eff),
    .valid_o(dv_b), .quot_o(qb)
  );
  tvg_divider u_div_s (
    .clk_i, .rst_ni, .valid_i(v0_q), .num_i(ns_q), .div_i(p_eff),
    .valid_o(dv_s), .quot_o(qs)
  );
  tvg_divider u_div_t (
    .clk_i, .rst_ni, .valid_i(v0_q), .num_i(nt_q), .div_i(p_eff),
    .valid_o(dv_t), .quot_o(qt)
  );

  logic                     cv_a, cv_b;
  logic signed [TRIG_W-1:0] ca, sa, cb, sb;

  tvg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_a (
    .clk_i, .rst_ni, .valid_i(dv_a), .phase_i(qa[PHASE_W-1:0]),
    .valid_o(cv_a), .cos_o(ca), .sin_o(sa)
  );
  tvg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_b (
    .clk_i, .rst_ni, .valid_i(dv_b), .phase_i(qb[PHASE_W-1:0]),
    .valid_o(cv_b), .cos_o(cb), .sin_o(sb)
  );

  logic  vx_v;
  geom_t geom;

  tvg_vertex u_vertex (
    .clk_i, .rst_ni, .valid_i(cv_a && cv_b),
    .ca_i(ca), .sa_i(sa), .cb_i(cb), .sb_i(sb),
    .ring_radius_i(ring_radius_q), .tube_radius_i(tube_radius_q),
    .valid_o(vx_v), .geom_o(geom)
  );

  // texcoords wait alongside the trig and vertex stages
  localparam int unsigned TEX_DLY = CORDIC_STAGES + VTX_LAT;

  logic [15:0] ts_q [TEX_DLY];
  logic [15:0] tt_q [TEX_DLY];

  always_ff @(posedge clk_i) begin
    ts_q[0] <= (dv_s && dv_t) ? qs[15:0] : qt[15:0] ^ qs[15:0] ^ qt[15:0];
    tt_q[0] <= qt[15:0];
    for (int i = 1; i < TEX_DLY; i++) begin
      ts_q[i] <= ts_q[i-1];
      tt_q[i] <= tt_q[i-1];
    end
  end

  always_comb begin
    result_o.pos_x            = geom.pos_x;
    result_o.pos_y            = geom.pos_y;
    result_o.pos_z            = geom.pos_z;
    result_o.normal_x         = geom.normal_x;
    result_o.normal_y         = geom.normal_y;
    result_o.normal_z         = geom.normal_z;
    result_o.tex_s            = ts_q[TEX_DLY-1];
    result_o.tex_t            = tt_q[TEX_DLY-1];
    result_o.bitangent_packed = geom.bitangent_packed;
    result_o.tangent_packed   = geom.tangent_packed;
  end

  assign valid_o = vx_v;

endmodule
